// ----- rtl/tfc_pkg.sv -----
// Package for the terrain facet classifier: shared constants, register
// indexes, class codes and the result/tag types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tfc_pkg;

   // Default geometry and sample width
   localparam int MAX_ROW_WIDTH_DEF = 4096;
   localparam int ELEV_BITS_DEF     = 24;

   // Configuration port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_ROW_WIDTH    = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ROW_COUNT    = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_NODATA_EN    = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_NODATA_VALUE = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_RECIP_8DX    = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_RECIP_8DY    = 3'd5;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_TAN_SQ_THR   = 3'd6;

   // Register reset values
   localparam logic [12:0] ROW_WIDTH_RST    = 13'd4096;
   localparam logic [15:0] ROW_COUNT_RST    = 16'd65535;
   localparam logic [23:0] NODATA_VALUE_RST = 24'h800000;
   localparam logic [31:0] RECIP_RST        = 32'd8192;
   localparam logic [31:0] TAN_SQ_THR_RST   = 32'd502;

   // Minimum row width / row count
   localparam int GEOM_MIN = 3;

   // tan(22.5 deg) in Q0.16, and saturation bound for Q16.16 slopes
   localparam logic [15:0] TAN_22_5_Q16 = 16'd27146;
   localparam logic [30:0] SAT_MAG      = 31'h7FFF_FFFF;

   // Facet classes
   localparam logic [3:0] CLASS_NODATA = 4'd0;
   localparam logic [3:0] CLASS_FLAT   = 4'd1;
   localparam logic [3:0] CLASS_N      = 4'd2;
   localparam logic [3:0] CLASS_NE     = 4'd3;
   localparam logic [3:0] CLASS_E      = 4'd4;
   localparam logic [3:0] CLASS_SE     = 4'd5;
   localparam logic [3:0] CLASS_S      = 4'd6;
   localparam logic [3:0] CLASS_SW     = 4'd7;
   localparam logic [3:0] CLASS_W      = 4'd8;
   localparam logic [3:0] CLASS_NW     = 4'd9;

   typedef struct packed {
      logic row_end;
      logic frame_end;
   } tfc_tag_type;

   typedef struct packed {
      logic [3:0]  facet_class;
      tfc_tag_type tag;
   } tfc_result_type;

endpackage

`default_nettype wire

// ----- rtl/tfc_req_if.sv -----
// Request channel: one elevation sample per request, valid/ready handshake.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface tfc_req_if #(
   parameter int ELEV_BITS = 24
);
   logic                        valid;
   logic                        ready;
   logic signed [ELEV_BITS-1:0] elevation;

   modport source (output valid, output elevation, input ready);
   modport sink   (input valid, input elevation, output ready);
endinterface

`default_nettype wire

// ----- rtl/tfc_rsp_if.sv -----
// Response channel: facet class with row/frame end marks, valid/ready.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface tfc_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] facet_class;
   logic       row_end;
   logic       frame_end;

   modport source (output valid, output facet_class, output row_end, output frame_end,
                   input ready);
   modport sink   (input valid, input facet_class, input row_end, input frame_end,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/tfc_ram.sv -----
// Generic simple dual-port RAM, one write and one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module tfc_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/terrain_facet_classifier.sv -----
// Top level of the terrain facet classifier: line memory, 3x3 window,
// gradient/classify pipeline and response buffer.
// Depends on tfc_pkg, tfc_req_if, tfc_rsp_if and tfc_ram.
`timescale 1ns / 1ps
`default_nettype none

// Streaming Horn slope/aspect classifier. Elevation samples arrive in raster
// order, one request per sample, and the block takes one sample per clock
// while the skid entry is free and no clearing pass runs. After reset a
// clearing pass zeroes the line memory; no request is taken during it, while
// configuration writes are. Every sample whose column and row are both at
// least 2 yields one response, which classifies the center one row up and
// one column left; border samples yield none. The two previous rows live in
// one RAM word per column ({upper, middle}), read when a sample is taken and
// written back when that sample leaves stage 1; the back-to-back read and
// write never hit the same column, since a row holds at least 3 samples.
// A two-entry response buffer keeps ready on the request side registered.
// Configuration should be written only while the block is idle.
module terrain_facet_classifier #(
   parameter int MAX_ROW_WIDTH = tfc_pkg::MAX_ROW_WIDTH_DEF,
   parameter int ELEV_BITS     = tfc_pkg::ELEV_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   tfc_req_if.sink                                req_chan,
   tfc_rsp_if.source                              rsp_chan,
   input  wire logic                              csr_we,
   input  wire logic [tfc_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [tfc_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int COL_BITS = $clog2(MAX_ROW_WIDTH);
   localparam int GW       = ELEV_BITS + 3;   // gradient width, signed
   localparam int PW       = GW + 32;         // |gradient| * reciprocal
   localparam int GEOM_W   = 17;              // compare width for geometry

   // ---------------------------------------------------------------- config
   logic        [12:0] row_width_ff;
   logic        [15:0] row_count_ff;
   logic               nodata_en_ff;
   logic signed [23:0] nodata_value_ff;
   logic        [31:0] recip_8dx_ff;
   logic        [31:0] recip_8dy_ff;
   logic        [31:0] tan_sq_thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff    <= tfc_pkg::ROW_WIDTH_RST;
         row_count_ff    <= tfc_pkg::ROW_COUNT_RST;
         nodata_en_ff    <= 1'b0;
         nodata_value_ff <= tfc_pkg::NODATA_VALUE_RST;
         recip_8dx_ff    <= tfc_pkg::RECIP_RST;
         recip_8dy_ff    <= tfc_pkg::RECIP_RST;
         tan_sq_thr_ff   <= tfc_pkg::TAN_SQ_THR_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            tfc_pkg::CSR_ROW_WIDTH:    row_width_ff    <= csr_wdata[12:0];
            tfc_pkg::CSR_ROW_COUNT:    row_count_ff    <= csr_wdata[15:0];
            tfc_pkg::CSR_NODATA_EN:    nodata_en_ff    <= csr_wdata[0];
            tfc_pkg::CSR_NODATA_VALUE: nodata_value_ff <= csr_wdata[23:0];
            tfc_pkg::CSR_RECIP_8DX:    recip_8dx_ff    <= csr_wdata;
            tfc_pkg::CSR_RECIP_8DY:    recip_8dy_ff    <= csr_wdata;
            tfc_pkg::CSR_TAN_SQ_THR:   tan_sq_thr_ff   <= csr_wdata;
            default: ;   // unmapped index, write dropped
         endcase
      end
   end

   // Effective geometry: width clamped to [3, MAX_ROW_WIDTH], rows to >= 3
   logic [GEOM_W-1:0] width_eff;
   logic [GEOM_W-1:0] rows_eff;

   always_comb begin
      priority if (GEOM_W'(row_width_ff) < GEOM_W'(tfc_pkg::GEOM_MIN)) begin
         width_eff = GEOM_W'(tfc_pkg::GEOM_MIN);
      end else if (GEOM_W'(row_width_ff) > GEOM_W'(MAX_ROW_WIDTH)) begin
         width_eff = GEOM_W'(MAX_ROW_WIDTH);
      end else begin
         width_eff = GEOM_W'(row_width_ff);
      end
      rows_eff = (GEOM_W'(row_count_ff) < GEOM_W'(tfc_pkg::GEOM_MIN)) ?
                 GEOM_W'(tfc_pkg::GEOM_MIN) : GEOM_W'(row_count_ff);
   end

   // -------------------------------------------------------- clearing pass
   logic                clr_active_ff;
   logic [COL_BITS-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == COL_BITS'(MAX_ROW_WIDTH - 1)) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------ flow control
   // The pipeline moves as a whole while the skid entry is free.
   logic skid_valid_ff;
   logic advance;
   logic accept;

   assign advance        = ~skid_valid_ff;
   assign req_chan.ready = advance & ~clr_active_ff;
   assign accept         = req_chan.valid & req_chan.ready;

   // ------------------------------------------------ stage 1: take sample
   logic [COL_BITS-1:0] col_ff;
   logic [COL_BITS-1:0] col_in;
   logic [15:0]         row_ff;
   logic [15:0]         row_in;
   logic                row_end;
   logic                frame_end;

   assign row_end   = (GEOM_W'(col_ff) + 1'b1) >= width_eff;
   assign frame_end = row_end && ((GEOM_W'(row_ff) + 1'b1) >= rows_eff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   logic                        s1_valid_ff;
   logic                        s1_emit_ff;
   tfc_pkg::tfc_tag_type        s1_tag_ff;
   logic signed [ELEV_BITS-1:0] s1_sample_ff;
   logic [COL_BITS-1:0]         s1_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff          <= (col_ff >= COL_BITS'(2)) && (row_ff >= 16'd2);
         s1_tag_ff.row_end   <= row_end;
         s1_tag_ff.frame_end <= frame_end;
         s1_sample_ff        <= req_chan.elevation;
         s1_col_ff           <= col_ff;
      end
   end

   // ------------------------------------------ line memory {upper, middle}
   logic                        ram_wr_en;
   logic [COL_BITS-1:0]         ram_wr_addr;
   logic [2*ELEV_BITS-1:0]      ram_wr_data;
   logic [2*ELEV_BITS-1:0]      ram_rd_data;
   logic signed [ELEV_BITS-1:0] line_up;
   logic signed [ELEV_BITS-1:0] line_mid;
   logic                        s1_step;

   assign s1_step  = s1_valid_ff & advance;
   assign line_up  = ram_rd_data[2*ELEV_BITS-1:ELEV_BITS];
   assign line_mid = ram_rd_data[ELEV_BITS-1:0];

   always_comb begin
      if (clr_active_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = '0;
      end else begin
         // middle row moves up, new sample becomes middle
         ram_wr_en   = s1_step;
         ram_wr_addr = s1_col_ff;
         ram_wr_data = {line_mid, s1_sample_ff};
      end
   end

   tfc_ram #(
      .WIDTH (2 * ELEV_BITS),
      .DEPTH (MAX_ROW_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------ stage 2: 3x3 window
   // win_ff[r*3 + k]: row r (0 upper, 2 newest), column k (2 newest)
   logic signed [ELEV_BITS-1:0] win_ff [9];
   logic                        s2_valid_ff;
   tfc_pkg::tfc_tag_type        s2_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_step) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r*3]     <= win_ff[r*3 + 1];
            win_ff[r*3 + 1] <= win_ff[r*3 + 2];
         end
         win_ff[2] <= line_up;
         win_ff[5] <= line_mid;
         win_ff[8] <= s1_sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff & s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_step) begin
         s2_tag_ff <= s1_tag_ff;
      end
   end

   // --------------------------------------------- stage 3: Horn gradients
   function automatic logic signed [GW-1:0] sx(input logic signed [ELEV_BITS-1:0] z);
      return GW'(z);
   endfunction

   logic signed [GW-1:0] gx;
   logic signed [GW-1:0] gy;
   logic                 center_nodata;

   assign gx = (sx(win_ff[2]) + (sx(win_ff[5]) <<< 1) + sx(win_ff[8]))
             - (sx(win_ff[0]) + (sx(win_ff[3]) <<< 1) + sx(win_ff[6]));
   assign gy = (sx(win_ff[6]) + (sx(win_ff[7]) <<< 1) + sx(win_ff[8]))
             - (sx(win_ff[0]) + (sx(win_ff[1]) <<< 1) + sx(win_ff[2]));
   assign center_nodata = nodata_en_ff &&
      ({{(33 - ELEV_BITS){win_ff[4][ELEV_BITS-1]}}, win_ff[4]} ==
       {{9{nodata_value_ff[23]}}, nodata_value_ff});

   logic                 s3_valid_ff;
   tfc_pkg::tfc_tag_type s3_tag_ff;
   logic                 s3_nodata_ff;
   logic [GW-1:0]        s3_gx_mag_ff;
   logic [GW-1:0]        s3_gy_mag_ff;
   logic                 s3_gx_neg_ff;
   logic                 s3_gy_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_tag_ff    <= s2_tag_ff;
         s3_nodata_ff <= center_nodata;
         s3_gx_mag_ff <= gx[GW-1] ? -gx : gx;
         s3_gy_mag_ff <= gy[GW-1] ? -gy : gy;
         s3_gx_neg_ff <= gx[GW-1];
         s3_gy_neg_ff <= gy[GW-1];
      end
   end

   // ---------------------------------------- stage 4: scale by reciprocal
   logic                 s4_valid_ff;
   tfc_pkg::tfc_tag_type s4_tag_ff;
   logic                 s4_nodata_ff;
   logic [PW-1:0]        s4_px_ff;
   logic [PW-1:0]        s4_py_ff;
   logic                 s4_gx_neg_ff;
   logic                 s4_gy_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_tag_ff    <= s3_tag_ff;
         s4_nodata_ff <= s3_nodata_ff;
         s4_px_ff     <= PW'(s3_gx_mag_ff) * PW'(recip_8dx_ff);
         s4_py_ff     <= PW'(s3_gy_mag_ff) * PW'(recip_8dy_ff);
         s4_gx_neg_ff <= s3_gx_neg_ff;
         s4_gy_neg_ff <= s3_gy_neg_ff;
      end
   end

   // ------------------------------------------------- stage 5: saturate
   // u = -dzdx, v = dzdy; only magnitudes and signs are carried on.
   logic                 s5_valid_ff;
   tfc_pkg::tfc_tag_type s5_tag_ff;
   logic                 s5_nodata_ff;
   logic [30:0]          s5_au_ff;
   logic [30:0]          s5_av_ff;
   logic                 s5_u_pos_ff;
   logic                 s5_v_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_tag_ff    <= s4_tag_ff;
         s5_nodata_ff <= s4_nodata_ff;
         s5_au_ff     <= (s4_px_ff > PW'(tfc_pkg::SAT_MAG)) ? tfc_pkg::SAT_MAG
                                                             : s4_px_ff[30:0];
         s5_av_ff     <= (s4_py_ff > PW'(tfc_pkg::SAT_MAG)) ? tfc_pkg::SAT_MAG
                                                             : s4_py_ff[30:0];
         // sign only matters where the magnitude is nonzero
         s5_u_pos_ff  <= s4_gx_neg_ff;
         s5_v_pos_ff  <= ~s4_gy_neg_ff;
      end
   end

   // ----------------------------------------- stage 6: squares and tan tests
   logic                 s6_valid_ff;
   tfc_pkg::tfc_tag_type s6_tag_ff;
   logic                 s6_nodata_ff;
   logic [61:0]          s6_usq_ff;
   logic [61:0]          s6_vsq_ff;
   logic [46:0]          s6_tu_ff;
   logic [46:0]          s6_tv_ff;
   logic [30:0]          s6_au_ff;
   logic [30:0]          s6_av_ff;
   logic                 s6_u_pos_ff;
   logic                 s6_v_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (advance) begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s6_tag_ff    <= s5_tag_ff;
         s6_nodata_ff <= s5_nodata_ff;
         s6_usq_ff    <= 62'(s5_au_ff) * 62'(s5_au_ff);
         s6_vsq_ff    <= 62'(s5_av_ff) * 62'(s5_av_ff);
         s6_tu_ff     <= 47'(s5_au_ff) * 47'(tfc_pkg::TAN_22_5_Q16);
         s6_tv_ff     <= 47'(s5_av_ff) * 47'(tfc_pkg::TAN_22_5_Q16);
         s6_au_ff     <= s5_au_ff;
         s6_av_ff     <= s5_av_ff;
         s6_u_pos_ff  <= s5_u_pos_ff;
         s6_v_pos_ff  <= s5_v_pos_ff;
      end
   end

   // ----------------------------------------------------------- classify
   logic [62:0]              grad_sq;
   logic                     is_flat;
   tfc_pkg::tfc_result_type  result;

   assign grad_sq = 63'(s6_usq_ff) + 63'(s6_vsq_ff);
   assign is_flat = grad_sq < 63'({tan_sq_thr_ff, 16'h0000});

   always_comb begin
      result.tag = s6_tag_ff;
      priority if (s6_nodata_ff) begin
         result.facet_class = tfc_pkg::CLASS_NODATA;
      end else if (is_flat) begin
         result.facet_class = tfc_pkg::CLASS_FLAT;
      end else if (s6_au_ff == '0 && s6_av_ff == '0) begin
         // zero gradient with zero threshold
         result.facet_class = tfc_pkg::CLASS_S;
      end else if ({s6_av_ff, 16'h0000} < s6_tu_ff) begin
         result.facet_class = s6_u_pos_ff ? tfc_pkg::CLASS_N : tfc_pkg::CLASS_S;
      end else if ({s6_au_ff, 16'h0000} < s6_tv_ff) begin
         result.facet_class = s6_v_pos_ff ? tfc_pkg::CLASS_E : tfc_pkg::CLASS_W;
      end else if (s6_u_pos_ff) begin
         result.facet_class = s6_v_pos_ff ? tfc_pkg::CLASS_NE : tfc_pkg::CLASS_NW;
      end else begin
         result.facet_class = s6_v_pos_ff ? tfc_pkg::CLASS_SE : tfc_pkg::CLASS_SW;
      end
   end

   // ---------------------------------------------------- response buffer
   // Output register plus one skid entry.
   logic                    out_valid_ff;
   logic                    out_valid_in;
   tfc_pkg::tfc_result_type out_ff;
   tfc_pkg::tfc_result_type out_in;
   logic                    skid_valid_in;
   tfc_pkg::tfc_result_type skid_ff;
   tfc_pkg::tfc_result_type skid_in;
   logic                    push;
   logic                    pop;

   assign push = s6_valid_ff & advance;
   assign pop  = out_valid_ff & rsp_chan.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (pop) begin
         priority if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_in = result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         if (out_valid_ff) begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = result;
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.facet_class = out_ff.facet_class;
   assign rsp_chan.row_end     = out_ff.tag.row_end;
   assign rsp_chan.frame_end   = out_ff.tag.frame_end;

endmodule

`default_nettype wire
